[src/bptc_pkg.sv]
package bptc_pkg;

    // Field and calibration widths.
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int PRESS_W    = 32;
    localparam int TEMP_OUT_W = 19;

    // Internal datapath widths, sized to the value ranges of each term.
    localparam int DT_W       = RAW_W + 1;
    localparam int TEMP_W     = TEMP_OUT_W + 1;
    localparam int PROD6_W    = DT_W + CAL_W + 1;
    localparam int DD_W       = 2 * DT_W;
    localparam int SQ_W       = 2 * TEMP_W;
    localparam int COR_W      = 41;
    localparam int PL_W       = 2 * RAW_W;
    localparam int SENS_HI_W  = COR_W - RAW_W;
    localparam int PH_W       = RAW_W + 1 + SENS_HI_W;
    localparam int X_W        = PH_W + RAW_W;
    localparam int Y_W        = 46;

    // Scaling shifts of the compensation formulas.
    localparam int C5_SHIFT   = 8;
    localparam int TEMP_SHIFT = 23;
    localparam int C2_SHIFT   = 17;
    localparam int C1_SHIFT   = 16;
    localparam int OFF_SHIFT  = 6;
    localparam int SENS_SHIFT = 7;
    localparam int TI_SHIFT   = 31;
    localparam int P1_SHIFT   = 21;
    localparam int P2_SHIFT   = 15;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Temperature thresholds in 0.01 C.
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;

    // Calibration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

    // Temperature band that selects the second-order correction.
    typedef enum logic [1:0] {
        BAND_NORMAL,
        BAND_COLD,
        BAND_VERY_COLD
    } t_band;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [DT_W-1:0]   dt;
        logic signed [TEMP_W-1:0] temp1;
        t_band                    band;
    } t_item;

endpackage

[src/bptc_front.sv]
module bptc_front import bptc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    input  t_cal             i_cal,
    output logic             o_valid,
    input  logic             i_stall,
    output t_item            o_item
);

    localparam logic signed [PROD6_W-1:0] TEMP_BIAS =
        $signed({{(PROD6_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{1'b1}}});

    logic                       r_f1_v;
    logic                       r_f2_v;
    logic [RAW_W-1:0]           r_f1_d1;
    logic [RAW_W-1:0]           r_f2_d1;
    logic signed [DT_W-1:0]     r_f1_dt;
    logic signed [DT_W-1:0]     r_f2_dt;
    logic signed [PROD6_W-1:0]  r_f2_prod;

    logic                       f1_rdy;
    logic                       f2_rdy;
    logic signed [DT_W-1:0]     n_f1_dt;
    logic signed [CAL_W:0]      c6_s;
    logic signed [PROD6_W-1:0]  n_f2_prod;
    logic signed [PROD6_W-1:0]  prod_biased;
    logic signed [PROD6_W-1:0]  prod_quot;
    logic signed [TEMP_W-1:0]   temp1;
    t_band                      band;

    // Each stage loads when it is empty or its successor moves on.
    assign f2_rdy  = !r_f2_v || !i_stall;
    assign f1_rdy  = !r_f1_v || f2_rdy;
    assign o_stall = !f1_rdy;

    // Stage 1: difference to the reference temperature.
    assign n_f1_dt = $signed({1'b0, i_raw_temperature})
                   - $signed({1'b0, i_cal.c5, {C5_SHIFT{1'b0}}});

    // Stage 2: dT times the temperature coefficient.
    assign c6_s      = $signed({1'b0, i_cal.c6});
    assign n_f2_prod = r_f1_dt * c6_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            if (f1_rdy) begin
                r_f1_v <= i_valid;
            end
            if (f2_rdy) begin
                r_f2_v <= r_f1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_rdy) begin
            r_f1_d1 <= i_raw_pressure;
            r_f1_dt <= n_f1_dt;
        end
        if (f2_rdy) begin
            r_f2_d1   <= r_f1_d1;
            r_f2_dt   <= r_f1_dt;
            r_f2_prod <= n_f2_prod;
        end
    end

    // First-order temperature, with the division truncating toward zero.
    assign prod_biased = r_f2_prod + (r_f2_prod[PROD6_W-1] ? TEMP_BIAS : '0);
    assign prod_quot   = prod_biased >>> TEMP_SHIFT;
    assign temp1       = TEMP_W'(prod_quot) + TEMP_REF;

    // Classify the sample by which correction the back must apply.
    always_comb begin
        priority if (temp1 < TEMP_COLD) begin
            band = BAND_VERY_COLD;
        end else if (temp1 < TEMP_REF) begin
            band = BAND_COLD;
        end else begin
            band = BAND_NORMAL;
        end
    end

    assign o_valid      = r_f2_v;
    assign o_item.d1    = r_f2_d1;
    assign o_item.dt    = r_f2_dt;
    assign o_item.temp1 = temp1;
    assign o_item.band  = band;

endmodule

[src/bptc_queue.sv]
module bptc_queue import bptc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_stall,
    output t_item o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               push;
    logic               pop;

    assign o_stall = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // Pointer wrap and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[src/bptc_back.sv]
module bptc_back import bptc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  t_item                     i_item,
    input  t_cal                      i_cal,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [PRESS_W-1:0] o_pressure,
    output logic signed [TEMP_OUT_W-1:0] o_temperature
);

    localparam logic signed [PROD6_W-1:0] OFF_BIAS =
        $signed({{(PROD6_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{1'b1}}});
    localparam logic signed [PROD6_W-1:0] SENS_BIAS =
        $signed({{(PROD6_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{1'b1}}});
    localparam logic signed [X_W-1:0] P1_BIAS =
        $signed({{(X_W-P1_SHIFT){1'b0}}, {P1_SHIFT{1'b1}}});
    localparam logic signed [Y_W-1:0] P2_BIAS =
        $signed({{(Y_W-P2_SHIFT){1'b0}}, {P2_SHIFT{1'b1}}});
    localparam logic signed [Y_W-1:0] P_MAX =
        $signed({{(Y_W-PRESS_W+1){1'b0}}, {(PRESS_W-1){1'b1}}});
    localparam logic signed [Y_W-1:0] P_MIN =
        $signed({{(Y_W-PRESS_W+1){1'b1}}, {(PRESS_W-1){1'b0}}});

    // Stage valid bits and load enables.
    logic r_b1_v, r_b2_v, r_b3_v, r_b4_v, r_b5_v, r_b6_v, r_b7_v;
    logic b1_rdy, b2_rdy, b3_rdy, b4_rdy, b5_rdy, b6_rdy, b7_rdy;

    // Stage 1: products of dT and of the band distances.
    logic [RAW_W-1:0]           r_b1_d1;
    logic signed [TEMP_W-1:0]   r_b1_temp1;
    t_band                      r_b1_band;
    logic signed [PROD6_W-1:0]  r_b1_m4;
    logic signed [PROD6_W-1:0]  r_b1_m3;
    logic signed [DD_W-1:0]     r_b1_dd;
    logic signed [SQ_W-1:0]     r_b1_aa;
    logic signed [SQ_W-1:0]     r_b1_bb;
    logic signed [TEMP_W-1:0]   dist_ref;
    logic signed [TEMP_W-1:0]   dist_cold;
    logic signed [CAL_W:0]      c4_s;
    logic signed [CAL_W:0]      c3_s;
    logic signed [PROD6_W-1:0]  n_b1_m4;
    logic signed [PROD6_W-1:0]  n_b1_m3;
    logic signed [DD_W-1:0]     n_b1_dd;
    logic signed [SQ_W-1:0]     n_b1_aa;
    logic signed [SQ_W-1:0]     n_b1_bb;

    // Stage 2: first-order offset and sensitivity, correction terms.
    logic [RAW_W-1:0]           r_b2_d1;
    logic signed [TEMP_W-1:0]   r_b2_temp1;
    logic signed [COR_W-1:0]    r_b2_off1;
    logic signed [COR_W-1:0]    r_b2_sens1;
    logic signed [TEMP_W-1:0]   r_b2_ti;
    logic signed [COR_W-1:0]    r_b2_t5;
    logic signed [COR_W-1:0]    r_b2_t7;
    logic signed [COR_W-1:0]    r_b2_t11;
    logic signed [COR_W-1:0]    c2_term;
    logic signed [COR_W-1:0]    c1_term;
    logic signed [PROD6_W-1:0]  m4_biased;
    logic signed [PROD6_W-1:0]  m3_biased;
    logic signed [COR_W-1:0]    aa_w;
    logic signed [COR_W-1:0]    bb_w;
    logic signed [COR_W-1:0]    n_b2_off1;
    logic signed [COR_W-1:0]    n_b2_sens1;
    logic signed [TEMP_W-1:0]   n_b2_ti;
    logic signed [COR_W-1:0]    n_b2_t5;
    logic signed [COR_W-1:0]    n_b2_t7;
    logic signed [COR_W-1:0]    n_b2_t11;

    // Stage 3: corrected temperature, offset and sensitivity.
    logic [RAW_W-1:0]           r_b3_d1;
    logic signed [TEMP_W-1:0]   r_b3_temp;
    logic signed [COR_W-1:0]    r_b3_off;
    logic signed [COR_W-1:0]    r_b3_sens;

    // Stage 4: partial products of D1 times SENS.
    logic signed [TEMP_W-1:0]   r_b4_temp;
    logic signed [COR_W-1:0]    r_b4_off;
    logic [PL_W-1:0]            r_b4_pl;
    logic signed [PH_W-1:0]     r_b4_ph;
    logic signed [SENS_HI_W-1:0] sens_hi;
    logic signed [RAW_W:0]      d1_s;
    logic signed [PH_W-1:0]     n_b4_ph;
    logic [PL_W-1:0]            n_b4_pl;

    // Stages 5 to 7: sum, scale, subtract offset, scale and clip.
    logic signed [TEMP_W-1:0]   r_b5_temp;
    logic signed [COR_W-1:0]    r_b5_off;
    logic signed [X_W-1:0]      r_b5_x;
    logic signed [TEMP_W-1:0]   r_b6_temp;
    logic signed [Y_W-1:0]      r_b6_y;
    logic signed [PRESS_W-1:0]  r_b7_press;
    logic signed [TEMP_OUT_W-1:0] r_b7_temp;
    logic signed [X_W-1:0]      n_b5_x;
    logic signed [X_W-1:0]      x_biased;
    logic signed [X_W-1:0]      x_quot;
    logic signed [Y_W-1:0]      n_b6_y;
    logic signed [Y_W-1:0]      y_biased;
    logic signed [Y_W-1:0]      y_quot;
    logic signed [PRESS_W-1:0]  n_b7_press;

    assign b7_rdy  = !r_b7_v || !i_stall;
    assign b6_rdy  = !r_b6_v || b7_rdy;
    assign b5_rdy  = !r_b5_v || b6_rdy;
    assign b4_rdy  = !r_b4_v || b5_rdy;
    assign b3_rdy  = !r_b3_v || b4_rdy;
    assign b2_rdy  = !r_b2_v || b3_rdy;
    assign b1_rdy  = !r_b1_v || b2_rdy;
    assign o_stall = !b1_rdy;

    // Stage 1 logic.
    assign dist_ref  = i_item.temp1 - TEMP_REF;
    assign dist_cold = i_item.temp1 - TEMP_COLD;
    assign c4_s      = $signed({1'b0, i_cal.c4});
    assign c3_s      = $signed({1'b0, i_cal.c3});
    assign n_b1_m4   = c4_s * i_item.dt;
    assign n_b1_m3   = c3_s * i_item.dt;
    assign n_b1_dd   = i_item.dt * i_item.dt;
    assign n_b1_aa   = dist_ref * dist_ref;
    assign n_b1_bb   = dist_cold * dist_cold;

    // Stage 2 logic: truncating divisions and band-gated corrections.
    assign c2_term    = $signed({{(COR_W-CAL_W-C2_SHIFT){1'b0}}, i_cal.c2, {C2_SHIFT{1'b0}}});
    assign c1_term    = $signed({{(COR_W-CAL_W-C1_SHIFT){1'b0}}, i_cal.c1, {C1_SHIFT{1'b0}}});
    assign m4_biased  = r_b1_m4 + (r_b1_m4[PROD6_W-1] ? OFF_BIAS : '0);
    assign m3_biased  = r_b1_m3 + (r_b1_m3[PROD6_W-1] ? SENS_BIAS : '0);
    assign n_b2_off1  = c2_term + COR_W'(m4_biased >>> OFF_SHIFT);
    assign n_b2_sens1 = c1_term + COR_W'(m3_biased >>> SENS_SHIFT);
    assign n_b2_ti    = (r_b1_band == BAND_NORMAL) ? '0 : TEMP_W'(r_b1_dd >>> TI_SHIFT);
    assign aa_w       = COR_W'(r_b1_aa);
    assign bb_w       = COR_W'(r_b1_bb);

    // The squares are non-negative, so plain shifts truncate correctly.
    always_comb begin
        unique case (r_b1_band)
            BAND_NORMAL: begin
                n_b2_t5  = '0;
                n_b2_t7  = '0;
                n_b2_t11 = '0;
            end
            BAND_COLD: begin
                n_b2_t5  = ((aa_w <<< 2) + aa_w) >>> 1;
                n_b2_t7  = '0;
                n_b2_t11 = '0;
            end
            BAND_VERY_COLD: begin
                n_b2_t5  = ((aa_w <<< 2) + aa_w) >>> 1;
                n_b2_t7  = (bb_w <<< 3) - bb_w;
                n_b2_t11 = (bb_w <<< 3) + (bb_w <<< 1) + bb_w;
            end
            default: begin
                n_b2_t5  = '0;
                n_b2_t7  = '0;
                n_b2_t11 = '0;
            end
        endcase
    end

    // Stage 4 logic: SENS split into an unsigned low part and a signed high part.
    assign sens_hi = $signed(r_b3_sens[COR_W-1:RAW_W]);
    assign d1_s    = $signed({1'b0, r_b3_d1});
    assign n_b4_pl = r_b3_d1 * r_b3_sens[RAW_W-1:0];
    assign n_b4_ph = d1_s * sens_hi;

    // Stage 5 logic: recombine the full product.
    assign n_b5_x = (X_W'(r_b4_ph) <<< RAW_W) + $signed(X_W'(r_b4_pl));

    // Stage 6 logic: scale by 2^21 toward zero and remove the offset.
    assign x_biased = r_b5_x + (r_b5_x[X_W-1] ? P1_BIAS : '0);
    assign x_quot   = x_biased >>> P1_SHIFT;
    assign n_b6_y   = Y_W'(x_quot) - Y_W'(r_b5_off);

    // Stage 7 logic: scale by 2^15 toward zero and clip to 32 bits.
    assign y_biased = r_b6_y + (r_b6_y[Y_W-1] ? P2_BIAS : '0);
    assign y_quot   = y_biased >>> P2_SHIFT;

    always_comb begin
        priority if (y_quot > P_MAX) begin
            n_b7_press = PRESS_W'(P_MAX);
        end else if (y_quot < P_MIN) begin
            n_b7_press = PRESS_W'(P_MIN);
        end else begin
            n_b7_press = PRESS_W'(y_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
            r_b5_v <= 1'b0;
            r_b6_v <= 1'b0;
            r_b7_v <= 1'b0;
        end else begin
            if (b1_rdy) begin
                r_b1_v <= i_valid;
            end
            if (b2_rdy) begin
                r_b2_v <= r_b1_v;
            end
            if (b3_rdy) begin
                r_b3_v <= r_b2_v;
            end
            if (b4_rdy) begin
                r_b4_v <= r_b3_v;
            end
            if (b5_rdy) begin
                r_b5_v <= r_b4_v;
            end
            if (b6_rdy) begin
                r_b6_v <= r_b5_v;
            end
            if (b7_rdy) begin
                r_b7_v <= r_b6_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b1_rdy) begin
            r_b1_d1    <= i_item.d1;
            r_b1_temp1 <= i_item.temp1;
            r_b1_band  <= i_item.band;
            r_b1_m4    <= n_b1_m4;
            r_b1_m3    <= n_b1_m3;
            r_b1_dd    <= n_b1_dd;
            r_b1_aa    <= n_b1_aa;
            r_b1_bb    <= n_b1_bb;
        end
        if (b2_rdy) begin
            r_b2_d1    <= r_b1_d1;
            r_b2_temp1 <= r_b1_temp1;
            r_b2_off1  <= n_b2_off1;
            r_b2_sens1 <= n_b2_sens1;
            r_b2_ti    <= n_b2_ti;
            r_b2_t5    <= n_b2_t5;
            r_b2_t7    <= n_b2_t7;
            r_b2_t11   <= n_b2_t11;
        end
        if (b3_rdy) begin
            r_b3_d1   <= r_b2_d1;
            r_b3_temp <= r_b2_temp1 - r_b2_ti;
            r_b3_off  <= r_b2_off1 - r_b2_t5 - r_b2_t7;
            r_b3_sens <= r_b2_sens1 - (r_b2_t5 >>> 1) - r_b2_t11;
        end
        if (b4_rdy) begin
            r_b4_temp <= r_b3_temp;
            r_b4_off  <= r_b3_off;
            r_b4_pl   <= n_b4_pl;
            r_b4_ph   <= n_b4_ph;
        end
        if (b5_rdy) begin
            r_b5_temp <= r_b4_temp;
            r_b5_off  <= r_b4_off;
            r_b5_x    <= n_b5_x;
        end
        if (b6_rdy) begin
            r_b6_temp <= r_b5_temp;
            r_b6_y    <= n_b6_y;
        end
        if (b7_rdy) begin
            r_b7_press <= n_b7_press;
            r_b7_temp  <= TEMP_OUT_W'(r_b6_temp);
        end
    end

    assign o_valid       = r_b7_v;
    assign o_pressure    = r_b7_press;
    assign o_temperature = r_b7_temp;

endmodule

[src/baro_pressure_temp_compensation.sv]
// Second-order barometric compensation: each transaction on the input channel carries one
// raw pressure and temperature conversion pair and yields one transaction with pressure in
// 0.01 mbar (saturated to 32 bits) and temperature in 0.01 C. The block is fully pipelined
// and accepts one transaction every cycle while o_stall is low. A transaction passes 2 front
// stages that compute dT and the first-order temperature and classify the sample, then the
// queue, then 7 back stages that apply the correction and form the pressure product in two
// partial products. The queue of QUEUE_DEPTH entries absorbs output stalls before the input
// stalls. Calibration words C1..C6 are written at indexes 0..5; the user must write them
// only while the block is idle, which the block does not enforce. Other indexes are ignored.
module baro_pressure_temp_compensation import bptc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [RAW_W-1:0]             i_raw_pressure,
    input  logic [RAW_W-1:0]             i_raw_temperature,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [PRESS_W-1:0]    o_pressure,
    output logic signed [TEMP_OUT_W-1:0] o_temperature,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CAL_W-1:0]             i_cfg_data
);

    t_cal  r_cal;
    t_cal  n_cal;
    logic  w_front_valid;
    logic  w_q_stall;
    t_item w_front_item;
    logic  w_q_valid;
    logic  w_back_stall;
    t_item w_q_item;

    // Calibration register file.
    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_C1:  n_cal.c1 = i_cfg_data;
                CFG_C2:  n_cal.c2 = i_cfg_data;
                CFG_C3:  n_cal.c3 = i_cfg_data;
                CFG_C4:  n_cal.c4 = i_cfg_data;
                CFG_C5:  n_cal.c5 = i_cfg_data;
                CFG_C6:  n_cal.c6 = i_cfg_data;
                default: n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    // Front: dT, first-order temperature and band classification.
    bptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (r_cal),
        .o_valid           (w_front_valid),
        .i_stall           (w_q_stall),
        .o_item            (w_front_item)
    );

    // Queue between the two halves.
    bptc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_stall (w_q_stall),
        .i_item  (w_front_item),
        .o_valid (w_q_valid),
        .i_stall (w_back_stall),
        .o_item  (w_q_item)
    );

    // Back: second-order correction and pressure.
    bptc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .o_stall       (w_back_stall),
        .i_item        (w_q_item),
        .i_cal         (r_cal),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pressure    (o_pressure),
        .o_temperature (o_temperature)
    );

    // The input is only held off when the front is full and the queue is full.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_front_valid && w_q_stall))
        else $error("input stalled without a full front and queue");

    // A queued transaction that the back does not take stays queued.
    a_queue_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_back_stall) |=> w_q_valid)
        else $error("queue lost a transaction while the back stalled");

    // A calibration write to C5 lands in its register.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_C5) |=> (r_cal.c5 == $past(i_cfg_data)))
        else $error("calibration write did not update the register");

endmodule
